@@ hdl/cdbv_pkg.sv @@
// ----------------------------------------------------------------------------
// cdbv_pkg: shared types and constants for the chunk directory blob validator
// Blob layout constants, status codes, config bundle and result beat layout.
// ----------------------------------------------------------------------------
package cdbv_pkg;

  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned ENTRY_BYTES   = 24;
  localparam int unsigned PAYLOAD_ALIGN = 32;  // power of two

  localparam int unsigned ENTRY_CW = $clog2(ENTRY_BYTES);
  localparam logic [63:0] ALIGN_MASK = 64'(PAYLOAD_ALIGN - 1);

  // "SKCB" read little-endian
  localparam logic [31:0] BLOB_MAGIC   = 32'h4243_4B53;
  localparam logic [15:0] BLOB_VERSION = 16'd1;

  // config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOB_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS = 2'd2;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SMALL      = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_CHUNK_BITS = 4'd4,
    ST_COUNT      = 4'd5,
    ST_TRAILING   = 4'd6,
    ST_DIRECTORY  = 4'd7,
    ST_UNSORTED   = 4'd8,
    ST_MISALIGNED = 4'd9,
    ST_PAYLOAD    = 4'd10,
    ST_LENGTH     = 4'd11
  } status_t;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_FINAL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [31:0] blob_size;
    logic [5:0]  bit_width;
    logic [15:0] max_chunks;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [63:0] entry_key;
    logic [31:0] pay_ofs;
    logic [31:0] pay_len;
    logic [15:0] chunk_total;
  } result_t;

endpackage

@@ hdl/cdbv_parse.sv @@
// ----------------------------------------------------------------------------
// cdbv_parse: per-byte blob parser and checker
// Holds the blob state, assembles header and directory fields, runs checks.
// ----------------------------------------------------------------------------
module cdbv_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  cdbv_pkg::cfg_t    cfg,
  input  logic              go,
  input  logic [7:0]        data_byte,
  input  logic              is_last,
  output logic              ent_v,
  output cdbv_pkg::result_t ent_res,
  output logic              fin_v,
  output cdbv_pkg::result_t fin_res
);
  import cdbv_pkg::*;

  localparam logic [3:0] POS_MAGIC_END   = 4'd3;
  localparam logic [3:0] POS_VERSION_END = 4'd5;
  localparam logic [3:0] POS_BITS_END    = 4'd7;
  localparam logic [3:0] POS_COUNT_END   = 4'd15;
  localparam logic [ENTRY_CW-1:0] OFF_ID_END   = ENTRY_CW'(7);
  localparam logic [ENTRY_CW-1:0] OFF_OFS_END  = ENTRY_CW'(15);
  localparam logic [ENTRY_CW-1:0] OFF_SIZE_END = ENTRY_CW'(ENTRY_BYTES - 1);

  logic [31:0]         p_r, p_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [15:0]         hcount_r, hcount_nxt;
  logic [15:0]         eidx_r, eidx_nxt;
  logic [ENTRY_CW-1:0] eoff_r, eoff_nxt;
  logic [63:0]         eid_r, eid_nxt;
  logic [63:0]         eofs_r, eofs_nxt;
  logic [63:0]         prev_r, prev_nxt;
  status_t             err_r, err_nxt;

  logic        hdr_phase, dir_phase;
  logic [2:0]  hdr_k;
  logic [32:0] dir_end;
  logic [32:0] fed;
  logic [63:0] limit;
  status_t     fin_st;

  // little-endian field assembly: lane 0 restarts the field
  function automatic logic [63:0] put_byte(logic [63:0] acc, logic [2:0] k, logic [7:0] b);
    logic [63:0] r;
    if (k == 3'd0) begin
      r = {56'd0, b};
    end else begin
      r = acc | ({56'd0, b} << {k, 3'b000});
    end
    return r;
  endfunction

  assign hdr_phase = (p_r < 32'(HEADER_BYTES));
  assign dir_phase = (eidx_r < hcount_r);
  assign limit     = {32'd0, cfg.blob_size};
  assign dir_end   = 33'(HEADER_BYTES) + (33'(acc_nxt[15:0]) << 4) + (33'(acc_nxt[15:0]) << 3);
  assign fed       = {1'b0, p_r} + 33'd1;

  always_comb begin
    // byte index within the current header field
    if (p_r[3:2] == 2'b00) begin
      hdr_k = {1'b0, p_r[1:0]};
    end else if (p_r[3:1] == 3'b010) begin
      hdr_k = {2'b00, p_r[0]};
    end else if (p_r[3:1] == 3'b011) begin
      hdr_k = {2'b00, p_r[0]};
    end else begin
      hdr_k = p_r[2:0];
    end
  end

  always_comb begin
    p_nxt      = p_r;
    acc_nxt    = acc_r;
    hcount_nxt = hcount_r;
    eidx_nxt   = eidx_r;
    eoff_nxt   = eoff_r;
    eid_nxt    = eid_r;
    eofs_nxt   = eofs_r;
    prev_nxt   = prev_r;
    err_nxt    = err_r;
    fin_st     = ST_OK;
    ent_v      = 1'b0;
    fin_v      = 1'b0;
    ent_res    = '0;
    fin_res    = '0;

    if (err_r == ST_OK) begin
      if (hdr_phase) begin
        if (p_r[3:0] == 4'd0 && cfg.blob_size < 32'(HEADER_BYTES)) begin
          err_nxt = ST_SMALL;
        end else begin
          acc_nxt = put_byte(acc_r, hdr_k, data_byte);
          case (p_r[3:0])
            POS_MAGIC_END: begin
              if (acc_nxt[31:0] != BLOB_MAGIC) err_nxt = ST_MAGIC;
            end
            POS_VERSION_END: begin
              if (acc_nxt[15:0] != BLOB_VERSION) err_nxt = ST_VERSION;
            end
            POS_BITS_END: begin
              if (acc_nxt[15:0] != {10'd0, cfg.bit_width}) err_nxt = ST_CHUNK_BITS;
            end
            POS_COUNT_END: begin
              if (acc_nxt > {48'd0, cfg.max_chunks}) begin
                err_nxt = ST_COUNT;
              end else begin
                hcount_nxt = acc_nxt[15:0];
                if (acc_nxt[15:0] == 16'd0) begin
                  if (cfg.blob_size != 32'(HEADER_BYTES)) err_nxt = ST_TRAILING;
                end else if (dir_end > {1'b0, cfg.blob_size}) begin
                  err_nxt = ST_DIRECTORY;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (dir_phase) begin
        acc_nxt  = put_byte(acc_r, eoff_r[2:0], data_byte);
        eoff_nxt = (eoff_r == OFF_SIZE_END) ? '0 : eoff_r + ENTRY_CW'(1);
        if (eoff_r == OFF_ID_END) begin
          eid_nxt = acc_nxt;
        end else if (eoff_r == OFF_OFS_END) begin
          eofs_nxt = acc_nxt;
        end else if (eoff_r == OFF_SIZE_END) begin
          if (eidx_r != 16'd0 && eid_r <= prev_r) begin
            err_nxt = ST_UNSORTED;
          end else begin
            prev_nxt = eid_r;
            if ((eofs_r & ALIGN_MASK) != 64'd0) begin
              err_nxt = ST_MISALIGNED;
            end else if (eofs_r > limit || acc_nxt > (limit - eofs_r)) begin
              err_nxt = ST_PAYLOAD;
            end
          end
          if (err_nxt == ST_OK) begin
            ent_v             = go;
            ent_res.kind      = KIND_ENTRY;
            ent_res.status    = ST_OK;
            ent_res.entry_key = eid_r;
            ent_res.pay_ofs   = eofs_r[31:0];
            ent_res.pay_len   = acc_nxt[31:0];
            eidx_nxt          = eidx_r + 16'd1;
          end
        end
      end
    end

    if (is_last) begin
      fin_st = err_nxt;
      if (fin_st == ST_OK) begin
        if (fed != {1'b0, cfg.blob_size} || fed < 33'(HEADER_BYTES) || eidx_nxt != hcount_nxt) begin
          fin_st = ST_LENGTH;
        end
      end
      fin_v               = go;
      fin_res.kind        = KIND_FINAL;
      fin_res.status      = fin_st;
      fin_res.chunk_total = hcount_nxt;
      // back to a clean slate for the next blob
      p_nxt      = '0;
      acc_nxt    = '0;
      hcount_nxt = '0;
      eidx_nxt   = '0;
      eoff_nxt   = '0;
      eid_nxt    = '0;
      eofs_nxt   = '0;
      prev_nxt   = '0;
      err_nxt    = ST_OK;
    end else if (p_r != '1) begin
      p_nxt = p_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r      <= '0;
      acc_r    <= '0;
      hcount_r <= '0;
      eidx_r   <= '0;
      eoff_r   <= '0;
      eid_r    <= '0;
      eofs_r   <= '0;
      prev_r   <= '0;
      err_r    <= ST_OK;
    end else if (go) begin
      p_r      <= p_nxt;
      acc_r    <= acc_nxt;
      hcount_r <= hcount_nxt;
      eidx_r   <= eidx_nxt;
      eoff_r   <= eoff_nxt;
      eid_r    <= eid_nxt;
      eofs_r   <= eofs_nxt;
      prev_r   <= prev_nxt;
      err_r    <= err_nxt;
    end
  end

  a_eidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    eidx_r <= hcount_r)
    else $error("entry index ran past header count");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    go && is_last |=> p_r == 32'd0 && err_r == ST_OK && eidx_r == 16'd0)
    else $error("blob state not cleared after last beat");

endmodule

@@ hdl/chunk_directory_blob_validator.sv @@
// ----------------------------------------------------------------------------
// chunk_directory_blob_validator: streaming chunked-bitmap blob checker
// Byte-wide blob in, accepted directory entries and one final status out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one blob byte per beat (in_data_byte), in_is_last on the
//   final byte. Output channel: one beat per accepted directory entry
//   (item_kind 0) and one final status beat per blob (item_kind 1) with the
//   first error found, or ok, and the header chunk count.
//   Config: program blob_size (and optionally the chunk-bit and count limits)
//   through cfg_* while the block is idle, before each blob.
//   Path: an accepted byte waits in the input register and is parsed once
//   both result slots are free; its result beat is registered in r0 for out_*.
//   Throughput: one byte per cycle while out_stall is low. The last byte of
//   a blob that also closes a directory entry yields two beats; the final
//   waits in r1, and no further byte is parsed until r1 drains.
//   Stall: out_stall holds the result register; the input register keeps its
//   byte (or takes one if empty) and in_stall rises until the results drain.
//   Reset: synchronous, active low. Clears the blob state and both channels;
//   config returns to blob_size 0, chunk bits 16, max chunks 4096.
// ----------------------------------------------------------------------------
module chunk_directory_blob_validator (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // blob byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [3:0]  out_status,
  output logic [63:0] out_chunk_id,
  output logic [31:0] out_payload_offset,
  output logic [31:0] out_payload_size,
  output logic [15:0] out_chunk_total
);
  import cdbv_pkg::*;

  cfg_t        cfg_r;

  // input register
  logic        in_v_r, in_v_nxt;
  logic [7:0]  byte_r;
  logic        last_r;

  // result pair: r0 drives the port, r1 holds a second beat (always a final)
  logic        r0_v_r, r0_v_nxt;
  logic        r1_v_r, r1_v_nxt;
  result_t     r0_r, r0_nxt;
  result_t     r1_r, r1_nxt;

  logic        pop, go, in_acc;
  logic        ent_v, fin_v;
  result_t     ent_res, fin_res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blob_size  <= 32'd0;
      cfg_r.bit_width  <= 6'd16;
      cfg_r.max_chunks <= 16'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOB_SIZE:  cfg_r.blob_size  <= cfg_wdata;
        CFG_CHUNK_BITS: cfg_r.bit_width  <= cfg_wdata[5:0];
        CFG_MAX_CHUNKS: cfg_r.max_chunks <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // parse the held byte once both result slots are free after this cycle's pop
  assign pop      = r0_v_r && !out_stall;
  assign go       = in_v_r && !r1_v_r && (!r0_v_r || pop);
  assign in_stall = in_v_r && !go;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (go) begin
      in_v_nxt = 1'b0;
    end
  end

  cdbv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .go        (go),
    .data_byte (byte_r),
    .is_last   (last_r),
    .ent_v     (ent_v),
    .ent_res   (ent_res),
    .fin_v     (fin_v),
    .fin_res   (fin_res)
  );

  always_comb begin
    r0_v_nxt = r0_v_r;
    r1_v_nxt = r1_v_r;
    r0_nxt   = r0_r;
    r1_nxt   = r1_r;
    if (pop) begin
      r0_v_nxt = r1_v_r;
      r0_nxt   = r1_r;
      r1_v_nxt = 1'b0;
    end
    if (go) begin
      if (ent_v) begin
        // entry beat goes out first, the final waits in r1
        r0_v_nxt = 1'b1;
        r0_nxt   = ent_res;
        if (fin_v) begin
          r1_v_nxt = 1'b1;
          r1_nxt   = fin_res;
        end
      end else if (fin_v) begin
        r0_v_nxt = 1'b1;
        r0_nxt   = fin_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      r0_v_r <= 1'b0;
      r1_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
      r0_v_r <= r0_v_nxt;
      r1_v_r <= r1_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_data_byte;
      last_r <= in_is_last;
    end
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
  end

  assign out_valid          = r0_v_r;
  assign out_item_kind      = r0_r.kind;
  assign out_status         = r0_r.status;
  assign out_chunk_id       = r0_r.entry_key;
  assign out_payload_offset = r0_r.pay_ofs;
  assign out_payload_size   = r0_r.pay_len;
  assign out_chunk_total    = r0_r.chunk_total;

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    r1_v_r |-> r0_v_r)
    else $error("second result slot full while first is empty");

  a_pair_final: assert property (@(posedge clk) disable iff (!rst_n)
    r1_v_r |-> r1_r.kind == KIND_FINAL)
    else $error("second result slot holds an entry beat");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    r0_v_r && r0_r.kind == KIND_ENTRY |-> r0_r.status == ST_OK)
    else $error("entry beat carries an error status");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && in_stall |=> in_v_r)
    else $error("held input byte dropped while stalled");

endmodule
